@@ src/crtt_pkg.sv @@
// ----------------------------------------------------------------------------
// crtt_pkg
// Shared types and constants of the command retry timeout table.
// ----------------------------------------------------------------------------
package crtt_pkg;

    localparam int TABLE_DEPTH_DEFAULT = 16;

    localparam int SEQ_W      = 16;
    localparam int CID_W      = 8;
    localparam int RETRY_W    = 4;
    localparam int TIME_W     = 32;
    localparam int INTERVAL_W = 16;
    localparam int CMD_W      = 2;
    localparam int KIND_W     = 3;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 32;

    localparam logic [INTERVAL_W-1:0] RETRY_INTERVAL_RESET = 16'd800;
    localparam logic [RETRY_W-1:0]    MAX_RETRIES_RESET    = 4'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_REG_RETRY_INTERVAL = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REG_MAX_RETRIES    = 4'd1;

    typedef enum logic [CMD_W-1:0] {
        CMD_SEND = 2'd0,
        CMD_ACK  = 2'd1,
        CMD_TICK = 2'd2
    } cmd_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_TRANSMIT   = 3'd0,
        KIND_RETRANSMIT = 3'd1,
        KIND_TIMEOUT    = 3'd2,
        KIND_ACK        = 3'd3,
        KIND_REJECT     = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_POST,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [SEQ_W-1:0]   seq;
        logic [CID_W-1:0]   cid;
        logic [RETRY_W-1:0] retries;
        logic [TIME_W-1:0]  deadline;
    } entry_t;

    typedef struct packed {
        kind_t              kind;
        logic [SEQ_W-1:0]   seq;
        logic [CID_W-1:0]   cid;
        logic [RETRY_W-1:0] attempt;
        logic               matched;
    } result_t;

    typedef struct packed {
        logic load;
        logic scan_adv;
        logic post;
        logic emit;
    } ctl_cmd_t;

    typedef struct packed {
        logic stage_v;
        logic res_hit;
        logic pend_v;
        logic out_free;
        logic scan_end;
        logic in_nop;
    } ctl_stat_t;

endpackage

@@ src/crtt_ctrl.sv @@
// ----------------------------------------------------------------------------
// crtt_ctrl
// Sequencer of the table: accept, slot scan, update, final beat.
// ----------------------------------------------------------------------------
module crtt_ctrl import crtt_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  ctl_stat_t stat,
    output ctl_cmd_t  cmd
);

    state_t state_reg, state_next;
    logic   advance;

    // hold the scan while a new result cannot leave the pending stage
    assign advance = !(stat.stage_v && stat.res_hit && stat.pend_v && !stat.out_free);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && !stat.in_nop) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (stat.scan_end) begin
                    state_next = ST_POST;
                end
            end
            ST_POST: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (!stat.pend_v || stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready     = 1'b0;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_SCAN: begin
                cmd.scan_adv = advance;
            end
            ST_POST: begin
                cmd.post = 1'b1;
            end
            ST_FINISH: begin
                cmd.emit = stat.pend_v && stat.out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

@@ src/crtt_datapath.sv @@
// ----------------------------------------------------------------------------
// crtt_datapath
// Entry memory kept in age order, scan pipeline, pending and output beats.
// ----------------------------------------------------------------------------
module crtt_datapath import crtt_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic [CMD_W-1:0]      s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic [KIND_W-1:0]     m_tuser,
    output logic                  m_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  ctl_cmd_t              cmd,
    output ctl_stat_t             stat
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    entry_t mem [TABLE_DEPTH];

    logic [CMD_W-1:0]      cmd_reg;
    logic [CID_W-1:0]      cid_reg;
    logic [SEQ_W-1:0]      aseq_reg;
    logic [TIME_W-1:0]     now_reg;
    logic [TIME_W-1:0]     newdl_reg;
    logic [INTERVAL_W-1:0] interval_reg;
    logic [RETRY_W-1:0]    max_reg;
    logic [SEQ_W-1:0]      next_seq_reg;
    logic [CNT_W-1:0]      count_reg, rd_ptr_reg, wr_ptr_reg;
    logic                  stage_v_reg, found_reg, pend_v_reg, out_v_reg, out_last_reg;
    entry_t                rd_data_reg;
    result_t               pend_reg, out_reg;

    logic [TIME_W:0]    dl_sum;
    logic [TIME_W-1:0]  newdl_next;
    logic               is_send, is_ack, is_tick;
    logic [SEQ_W-1:0]   key;
    logic               seq_hit, due, expire, keep;
    logic [RETRY_W-1:0] retries_inc;
    entry_t             e_upd, new_entry;
    result_t            tick_res, post_res;
    logic               eval_go, fetch, full, append, push, out_free;
    logic               wr_en;
    entry_t             wr_data;
    logic [IDX_W-1:0]   wr_idx;

    // saturating deadline from the incoming beat
    assign dl_sum     = {1'b0, s_tdata[55:24]} + {{(TIME_W + 1 - INTERVAL_W){1'b0}}, interval_reg};
    assign newdl_next = dl_sum[TIME_W] ? {TIME_W{1'b1}} : dl_sum[TIME_W-1:0];

    assign is_send = (cmd_reg == CMD_SEND);
    assign is_ack  = (cmd_reg == CMD_ACK);
    assign is_tick = (cmd_reg == CMD_TICK);
    assign key     = is_ack ? aseq_reg : next_seq_reg;

    assign seq_hit     = !is_tick && (rd_data_reg.seq == key) && !(is_ack && found_reg);
    assign due         = is_tick && (rd_data_reg.deadline <= now_reg);
    assign expire      = due && (rd_data_reg.retries >= max_reg);
    assign keep        = !seq_hit && !expire;
    assign retries_inc = rd_data_reg.retries + 1'b1;

    always_comb begin
        e_upd = rd_data_reg;
        if (due && !expire) begin
            e_upd.retries  = retries_inc;
            e_upd.deadline = newdl_reg;
        end
    end

    always_comb begin
        tick_res.kind    = expire ? KIND_TIMEOUT : KIND_RETRANSMIT;
        tick_res.seq     = rd_data_reg.seq;
        tick_res.cid     = rd_data_reg.cid;
        tick_res.attempt = expire ? rd_data_reg.retries : retries_inc;
        tick_res.matched = 1'b0;
    end

    assign eval_go  = cmd.scan_adv && stage_v_reg;
    assign fetch    = cmd.scan_adv && (rd_ptr_reg < count_reg);
    assign full     = (wr_ptr_reg == CNT_W'(TABLE_DEPTH));
    assign append   = cmd.post && is_send && !full;
    assign out_free = !out_v_reg || m_tready;
    assign push     = eval_go && due && pend_v_reg;

    assign new_entry.seq      = next_seq_reg;
    assign new_entry.cid      = cid_reg;
    assign new_entry.retries  = '0;
    assign new_entry.deadline = newdl_reg;

    always_comb begin
        post_res = '0;
        if (is_send) begin
            post_res.kind = full ? KIND_REJECT : KIND_TRANSMIT;
            post_res.seq  = full ? '0 : next_seq_reg;
            post_res.cid  = cid_reg;
        end else begin
            post_res.kind = KIND_ACK;
            post_res.seq  = aseq_reg;
        end
    end

    assign wr_en   = (eval_go && keep) || append;
    assign wr_data = append ? new_entry : e_upd;
    assign wr_idx  = wr_ptr_reg[IDX_W-1:0];

    // entry memory: one write, one registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_data;
        end
        if (fetch) begin
            rd_data_reg <= mem[rd_ptr_reg[IDX_W-1:0]];
        end
    end

    // item payload
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cmd_reg   <= s_tuser;
            cid_reg   <= s_tdata[7:0];
            aseq_reg  <= s_tdata[23:8];
            now_reg   <= s_tdata[55:24];
            newdl_reg <= newdl_next;
        end
    end

    // scan control and table state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interval_reg <= RETRY_INTERVAL_RESET;
            max_reg      <= MAX_RETRIES_RESET;
            next_seq_reg <= '0;
            count_reg    <= '0;
            rd_ptr_reg   <= '0;
            wr_ptr_reg   <= '0;
            stage_v_reg  <= 1'b0;
            found_reg    <= 1'b0;
            pend_v_reg   <= 1'b0;
        end else begin
            if (cfg_valid && cfg_index == CFG_REG_RETRY_INTERVAL) begin
                interval_reg <= cfg_data;
            end
            if (cfg_valid && cfg_index == CFG_REG_MAX_RETRIES) begin
                max_reg <= cfg_data[RETRY_W-1:0];
            end
            if (cmd.load) begin
                rd_ptr_reg  <= '0;
                wr_ptr_reg  <= '0;
                stage_v_reg <= 1'b0;
                found_reg   <= 1'b0;
                pend_v_reg  <= 1'b0;
            end
            if (cmd.scan_adv) begin
                stage_v_reg <= fetch;
                if (fetch) begin
                    rd_ptr_reg <= rd_ptr_reg + 1'b1;
                end
            end
            if (eval_go && keep) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (eval_go && due) begin
                pend_v_reg <= 1'b1;
            end
            if (eval_go && seq_hit && is_ack) begin
                found_reg  <= 1'b1;
                pend_v_reg <= 1'b1;
            end
            if (cmd.post) begin
                count_reg <= append ? CNT_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
                if (append) begin
                    next_seq_reg <= next_seq_reg + 1'b1;
                end
                if (is_send || (is_ack && !found_reg)) begin
                    pend_v_reg <= 1'b1;
                end
            end
            if (cmd.emit) begin
                pend_v_reg <= 1'b0;
            end
        end
    end

    // pending result payload
    always_ff @(posedge aclk) begin
        if (eval_go && due) begin
            pend_reg <= tick_res;
        end else if (eval_go && seq_hit && is_ack) begin
            pend_reg.kind    <= KIND_ACK;
            pend_reg.seq     <= aseq_reg;
            pend_reg.cid     <= rd_data_reg.cid;
            pend_reg.attempt <= rd_data_reg.retries;
            pend_reg.matched <= 1'b1;
        end else if (cmd.post && (is_send || (is_ack && !found_reg))) begin
            pend_reg <= post_res;
        end
    end

    // output beat register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (push || cmd.emit) begin
            out_v_reg <= 1'b1;
        end else if (m_tready) begin
            out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (push || cmd.emit) begin
            out_reg      <= pend_reg;
            out_last_reg <= cmd.emit;
        end
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_v_reg;
    assign m_tdata   = {3'b000, out_reg.matched, out_reg.attempt, out_reg.cid, out_reg.seq};
    assign m_tuser   = out_reg.kind;
    assign m_tlast   = out_last_reg;

    assign stat.stage_v  = stage_v_reg;
    assign stat.res_hit  = due;
    assign stat.pend_v   = pend_v_reg;
    assign stat.out_free = out_free;
    assign stat.scan_end = !stage_v_reg && (rd_ptr_reg == count_reg);
    assign stat.in_nop   = !(s_tuser == CMD_SEND || s_tuser == CMD_ACK || s_tuser == CMD_TICK);

endmodule

@@ src/command_retry_timeout_table_core.sv @@
// ----------------------------------------------------------------------------
// command_retry_timeout_table_core
// Retransmission table for commands waiting on an acknowledgement.
// ----------------------------------------------------------------------------
// Items are taken one at a time. Every send, ack or tick walks the live
// entries, kept oldest first in an entry memory with one write and one
// registered read port, one entry per cycle while m_tready does not hold
// back result beats. A send or ack gives one beat; a tick gives one beat
// per due entry, none if nothing is due, with tlast on the final one. The
// unused cmd code is dropped on accept. The registered beat at the output
// lets the next item enter while it waits.
module command_retry_timeout_table_core import crtt_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // cid[7:0], ack_seq[23:8], now_ms[55:24]
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // cmd[1:0]
    input  logic [CMD_W-1:0]      s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // seq[15:0], result_cid[23:16], attempt[27:24], ack_matched[28], zero[31:29]
    output logic [M_TDATA_W-1:0]  m_tdata,
    // kind[2:0]
    output logic [KIND_W-1:0]     m_tuser,
    output logic                  m_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    ctl_cmd_t  cmd;
    ctl_stat_t stat;

    crtt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    crtt_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

@@ src/crtt_checker.sv @@
// ----------------------------------------------------------------------------
// crtt_checker
// Port-level checks on the result beats of the retry table.
// ----------------------------------------------------------------------------
module crtt_checker import crtt_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [KIND_W-1:0]    m_tuser,
    input logic                 m_tlast
);

    // a stalled beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // match flag only on ack beats
    a_match_ack_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[28] |-> m_tuser == KIND_ACK)
        else $error("ack_matched set on a non-ack beat");

    // send and ack items give exactly one beat, so it carries tlast
    a_single_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_TRANSMIT || m_tuser == KIND_ACK
            || m_tuser == KIND_REJECT) |-> m_tlast)
        else $error("single-beat result without tlast");

    // a reject carries no sequence and no attempt
    a_reject_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_REJECT |-> m_tdata[15:0] == '0 && m_tdata[27:24] == '0)
        else $error("reject beat with sequence or attempt set");

endmodule

bind command_retry_timeout_table_core crtt_checker u_crtt_checker (.*);
